@@ hw/rtl/gcli_pkg.sv @@
// Shared types and constants for the great circle / latitude plane intersect core.
// Used by gcli_mul and great_circle_latitude_intersect_core; no dependencies.
package gcli_pkg;

   localparam int FRAC_BITS_DEFAULT = 30;
   // multiplier pipelines retire this many bits of the second operand per stage
   localparam int DIGIT_BITS = 8;

   typedef enum logic [1:0] {
      STATUS_VALID      = 2'd0,
      STATUS_NO_HIT     = 2'd1,
      STATUS_DEGENERATE = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] plane_height;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [1:0]         status;
   } rsp_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

@@ hw/rtl/gcli_mul.sv @@
// Pipelined unsigned multiplier, one digit of the second operand per stage,
// with a valid bit and a side bus that travel alongside. Depends on gcli_pkg.
module gcli_mul #(
   parameter int A_WIDTH    = 64,
   parameter int B_WIDTH    = 64,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       valid_in,
   input  logic [A_WIDTH-1:0]         a_in,
   input  logic [B_WIDTH-1:0]         b_in,
   input  logic [SIDE_WIDTH-1:0]      side_in,
   output logic                       valid_out,
   output logic [A_WIDTH+B_WIDTH-1:0] product,
   output logic [SIDE_WIDTH-1:0]      side_out
);
   import gcli_pkg::*;

   localparam int NS = (B_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int BP = NS * DIGIT_BITS;
   localparam int PW = A_WIDTH + B_WIDTH;

   logic                        valid_ff [NS];
   logic [PW-1:0]               acc_ff   [NS];
   logic [A_WIDTH-1:0]          a_ff     [NS];
   logic [BP-1:0]               b_ff     [NS];
   logic [SIDE_WIDTH-1:0]       side_ff  [NS];
   logic [A_WIDTH+DIGIT_BITS-1:0] part   [NS];
   logic [BP-1:0]               b_pad;

   assign b_pad = BP'(b_in);

   for (genvar g = 0; g < NS; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign part[0] = {{DIGIT_BITS{1'b0}}, a_in} * b_pad[DIGIT_BITS-1:0];
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[0] <= 1'b0;
            end else begin
               valid_ff[0] <= valid_in;
            end
            acc_ff[0]  <= PW'(part[0]);
            a_ff[0]    <= a_in;
            b_ff[0]    <= b_pad;
            side_ff[0] <= side_in;
         end
      end else begin : g_next
         assign part[g] = {{DIGIT_BITS{1'b0}}, a_ff[g-1]} *
                          b_ff[g-1][g*DIGIT_BITS +: DIGIT_BITS];
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[g] <= 1'b0;
            end else begin
               valid_ff[g] <= valid_ff[g-1];
            end
            acc_ff[g]  <= acc_ff[g-1] + (PW'(part[g]) << (g * DIGIT_BITS));
            a_ff[g]    <= a_ff[g-1];
            b_ff[g]    <= b_ff[g-1];
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   assign valid_out = valid_ff[NS-1];
   assign product   = acc_ff[NS-1];
   assign side_out  = side_ff[NS-1];

endmodule

@@ hw/rtl/great_circle_latitude_intersect_core.sv @@
// Top level of the great circle / latitude plane intersect core.
// Depends on gcli_pkg and gcli_mul.
//
// Usage:
//   An item (points A, B and plane height, fixed point with FRAC_BITS fraction
//   bits) is taken on req_item at each rising edge where start is high and busy
//   is low. busy is never raised: the pipeline takes one item every cycle.
//   Each result shows on rsp_item for one cycle with rsp_valid high, in input
//   order. The square root takes NR stages, NR = (max(128+2*FRAC_BITS, 192)+1)/2,
//   one root bit per stage; the two divisions take 32 stages, one quotient
//   bit per stage; every gcli_mul multiply retires 8 bits of one operand per stage.
//   status: valid, no intersection (negative discriminant) or degenerate
//   (nx^2+ny^2 is zero); the points read 0 unless valid, and saturate.
//   Reset (synchronous) clears all valid bits; items in flight are dropped.
//   The receiver cannot stall: results are not held.
module great_circle_latitude_intersect_core #(
   parameter int FRAC_BITS = gcli_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gcli_pkg::req_type req_item,
   output logic              rsp_valid,
   output gcli_pkg::rsp_type rsp_item
);
   import gcli_pkg::*;

   localparam int LHS_W   = 128 + 2 * FRAC_BITS;
   localparam int RHS_W   = 192;
   localparam int QW      = max_int(LHS_W, RHS_W);
   localparam int NR      = (QW + 1) / 2;
   localparam int T1_W    = 160;
   localparam int T2_W    = NR + 64;
   localparam int SW      = max_int(T1_W, T2_W) + 2;
   localparam int MW      = SW - 1;
   localparam int DVW     = max_int(MW, 128 + 33);
   localparam int LATENCY = 67 + NR;

   typedef struct packed {
      logic [63:0] mx;
      logic [63:0] my;
      logic [63:0] mz;
      logic        sx;
      logic        sy;
      logic        sz;
      logic        s0;
   } ga_side_type;

   typedef struct packed {
      logic [127:0] d;
      logic [63:0]  mx;
      logic [63:0]  my;
      logic         n1x;
      logic         n1y;
      logic         n2x;
      logic         n2y;
   } gb_side_type;

   typedef struct packed {
      logic [T1_W-1:0] t1x;
      logic [T1_W-1:0] t1y;
      logic [127:0]    d;
      logic [63:0]     mx;
      logic [63:0]     my;
      logic            n1x;
      logic            n1y;
      logic            n2x;
      logic            n2y;
      status_type      status;
   } sq_side_type;

   typedef struct packed {
      logic [T1_W-1:0] t1x;
      logic [T1_W-1:0] t1y;
      logic [127:0]    d;
      logic            n1x;
      logic            n1y;
      logic            n2x;
      logic            n2y;
      status_type      status;
   } ge_side_type;

   assign busy = 1'b0;

   // ---- cross product terms
   logic               s1_valid_ff;
   logic signed [63:0] s1_aybz_ff, s1_azby_ff, s1_azbx_ff;
   logic signed [63:0] s1_axbz_ff, s1_axby_ff, s1_aybx_ff;
   logic [31:0]        s1_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_aybz_ff <= 64'(req_item.a_y * req_item.b_z);
      s1_azby_ff <= 64'(req_item.a_z * req_item.b_y);
      s1_azbx_ff <= 64'(req_item.a_z * req_item.b_x);
      s1_axbz_ff <= 64'(req_item.a_x * req_item.b_z);
      s1_axby_ff <= 64'(req_item.a_x * req_item.b_y);
      s1_aybx_ff <= 64'(req_item.a_y * req_item.b_x);
      s1_z_ff    <= req_item.plane_height;
   end

   logic        s2_valid_ff;
   logic [64:0] s2_nx_ff, s2_ny_ff, s2_nz_ff;
   logic [31:0] s2_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_nx_ff <= {s1_aybz_ff[63], s1_aybz_ff} - {s1_azby_ff[63], s1_azby_ff};
      s2_ny_ff <= {s1_azbx_ff[63], s1_azbx_ff} - {s1_axbz_ff[63], s1_axbz_ff};
      s2_nz_ff <= {s1_axby_ff[63], s1_axby_ff} - {s1_aybx_ff[63], s1_aybx_ff};
      s2_z_ff  <= s1_z_ff;
   end

   // ---- magnitudes and signs; |n| stays below 2^63
   logic        s3_valid_ff;
   ga_side_type s3_side_ff;
   logic [31:0] s3_mzz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_side_ff.mx <= s2_nx_ff[64] ? 64'(-s2_nx_ff) : s2_nx_ff[63:0];
      s3_side_ff.my <= s2_ny_ff[64] ? 64'(-s2_ny_ff) : s2_ny_ff[63:0];
      s3_side_ff.mz <= s2_nz_ff[64] ? 64'(-s2_nz_ff) : s2_nz_ff[63:0];
      s3_side_ff.sx <= s2_nx_ff[64];
      s3_side_ff.sy <= s2_ny_ff[64];
      s3_side_ff.sz <= s2_nz_ff[64];
      s3_side_ff.s0 <= s2_z_ff[31];
      s3_mzz_ff     <= s2_z_ff[31] ? (~s2_z_ff + 32'd1) : s2_z_ff;
   end

   // ---- squares and z products
   logic        ga_valid;
   ga_side_type ga_side;
   logic [127:0] ga_xx, ga_yy, ga_zz, ga_zx, ga_zy;
   logic [95:0]  ga_z2;

   gcli_mul #(.A_WIDTH(64), .B_WIDTH(64), .SIDE_WIDTH($bits(ga_side_type))) u_mul_xx (
      .clock, .reset, .valid_in(s3_valid_ff), .a_in(s3_side_ff.mx), .b_in(s3_side_ff.mx),
      .side_in(s3_side_ff), .valid_out(ga_valid), .product(ga_xx), .side_out(ga_side));
   gcli_mul #(.A_WIDTH(64), .B_WIDTH(64), .SIDE_WIDTH(1)) u_mul_yy (
      .clock, .reset, .valid_in(s3_valid_ff), .a_in(s3_side_ff.my), .b_in(s3_side_ff.my),
      .side_in(1'b0), .valid_out(), .product(ga_yy), .side_out());
   gcli_mul #(.A_WIDTH(64), .B_WIDTH(64), .SIDE_WIDTH(1)) u_mul_zz (
      .clock, .reset, .valid_in(s3_valid_ff), .a_in(s3_side_ff.mz), .b_in(s3_side_ff.mz),
      .side_in(1'b0), .valid_out(), .product(ga_zz), .side_out());
   gcli_mul #(.A_WIDTH(32), .B_WIDTH(64), .SIDE_WIDTH(1)) u_mul_z2 (
      .clock, .reset, .valid_in(s3_valid_ff), .a_in(s3_mzz_ff), .b_in(64'(s3_mzz_ff)),
      .side_in(1'b0), .valid_out(), .product(ga_z2), .side_out());
   gcli_mul #(.A_WIDTH(64), .B_WIDTH(64), .SIDE_WIDTH(1)) u_mul_zx (
      .clock, .reset, .valid_in(s3_valid_ff), .a_in(s3_side_ff.mx), .b_in(64'(s3_mzz_ff)),
      .side_in(1'b0), .valid_out(), .product(ga_zx), .side_out());
   gcli_mul #(.A_WIDTH(64), .B_WIDTH(64), .SIDE_WIDTH(1)) u_mul_zy (
      .clock, .reset, .valid_in(s3_valid_ff), .a_in(s3_side_ff.my), .b_in(64'(s3_mzz_ff)),
      .side_in(1'b0), .valid_out(), .product(ga_zy), .side_out());

   logic         b1_valid_ff;
   logic [127:0] b1_nn_ff;
   logic [63:0]  b1_z2_ff;
   logic [95:0]  b1_zx_ff, b1_zy_ff;
   gb_side_type  b1_side_ff;
   logic [63:0]  b1_mz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= ga_valid;
      end
      b1_nn_ff       <= ga_xx + ga_yy + ga_zz;
      b1_z2_ff       <= ga_z2[63:0];
      b1_zx_ff       <= ga_zx[95:0];
      b1_zy_ff       <= ga_zy[95:0];
      b1_mz_ff       <= ga_side.mz;
      b1_side_ff.d   <= ga_xx + ga_yy;
      b1_side_ff.mx  <= ga_side.mx;
      b1_side_ff.my  <= ga_side.my;
      b1_side_ff.n1x <= ga_side.s0 ^ ga_side.sx ^ ga_side.sz;
      b1_side_ff.n1y <= ga_side.s0 ^ ga_side.sy ^ ga_side.sz;
      b1_side_ff.n2x <= ga_side.sy;
      b1_side_ff.n2y <= !ga_side.sx;
   end

   // ---- |n|^2 * z^2 and z*n*nz terms
   logic            gb_valid;
   gb_side_type     gb_side;
   logic [191:0]    gb_rhs;
   logic [T1_W-1:0] gb_t1x, gb_t1y;

   gcli_mul #(.A_WIDTH(128), .B_WIDTH(64), .SIDE_WIDTH($bits(gb_side_type))) u_mul_rhs (
      .clock, .reset, .valid_in(b1_valid_ff), .a_in(b1_nn_ff), .b_in(b1_z2_ff),
      .side_in(b1_side_ff), .valid_out(gb_valid), .product(gb_rhs), .side_out(gb_side));
   gcli_mul #(.A_WIDTH(96), .B_WIDTH(64), .SIDE_WIDTH(1)) u_mul_t1x (
      .clock, .reset, .valid_in(b1_valid_ff), .a_in(b1_zx_ff), .b_in(b1_mz_ff),
      .side_in(1'b0), .valid_out(), .product(gb_t1x), .side_out());
   gcli_mul #(.A_WIDTH(96), .B_WIDTH(64), .SIDE_WIDTH(1)) u_mul_t1y (
      .clock, .reset, .valid_in(b1_valid_ff), .a_in(b1_zy_ff), .b_in(b1_mz_ff),
      .side_in(1'b0), .valid_out(), .product(gb_t1y), .side_out());

   // ---- discriminant, then square root one bit per stage (stage 0 is the setup)
   logic        sq_valid_ff [NR+1];
   logic [QW:0] sq_num_ff   [NR+1];
   logic [QW:0] sq_res_ff   [NR+1];
   sq_side_type sq_side_ff  [NR+1];

   logic [QW:0] c1_diff;
   status_type  c1_status;

   always_comb begin
      c1_diff = {1'b0, QW'(gb_side.d) << (2 * FRAC_BITS)} - (QW+1)'(gb_rhs);
      if (gb_side.d == '0) begin
         c1_status = STATUS_DEGENERATE;
      end else if (c1_diff[QW]) begin
         c1_status = STATUS_NO_HIT;
      end else begin
         c1_status = STATUS_VALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= gb_valid;
      end
      sq_num_ff[0]         <= (c1_status == STATUS_VALID) ? c1_diff : '0;
      sq_res_ff[0]         <= '0;
      sq_side_ff[0].t1x    <= gb_t1x;
      sq_side_ff[0].t1y    <= gb_t1y;
      sq_side_ff[0].d      <= gb_side.d;
      sq_side_ff[0].mx     <= gb_side.mx;
      sq_side_ff[0].my     <= gb_side.my;
      sq_side_ff[0].n1x    <= gb_side.n1x;
      sq_side_ff[0].n1y    <= gb_side.n1y;
      sq_side_ff[0].n2x    <= gb_side.n2x;
      sq_side_ff[0].n2y    <= gb_side.n2y;
      sq_side_ff[0].status <= c1_status;
   end

   for (genvar k = 1; k <= NR; k++) begin : g_sqrt
      localparam logic [QW:0] SQ_BIT = {{QW{1'b0}}, 1'b1} << (2 * (NR - k));
      logic [QW:0] trial, num_in, res_in;
      logic        take;

      always_comb begin
         trial  = sq_res_ff[k-1] + SQ_BIT;
         take   = sq_num_ff[k-1] >= trial;
         num_in = take ? (sq_num_ff[k-1] - trial) : sq_num_ff[k-1];
         res_in = (sq_res_ff[k-1] >> 1) + (take ? SQ_BIT : '0);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else begin
            sq_valid_ff[k] <= sq_valid_ff[k-1];
         end
         sq_num_ff[k]  <= num_in;
         sq_res_ff[k]  <= res_in;
         sq_side_ff[k] <= sq_side_ff[k-1];
      end
   end

   // ---- root times n
   logic            ge_valid;
   ge_side_type     ge_side_in, ge_side;
   logic [T2_W-1:0] ge_t2x, ge_t2y;

   always_comb begin
      ge_side_in.t1x    = sq_side_ff[NR].t1x;
      ge_side_in.t1y    = sq_side_ff[NR].t1y;
      ge_side_in.d      = sq_side_ff[NR].d;
      ge_side_in.n1x    = sq_side_ff[NR].n1x;
      ge_side_in.n1y    = sq_side_ff[NR].n1y;
      ge_side_in.n2x    = sq_side_ff[NR].n2x;
      ge_side_in.n2y    = sq_side_ff[NR].n2y;
      ge_side_in.status = sq_side_ff[NR].status;
   end

   gcli_mul #(.A_WIDTH(NR), .B_WIDTH(64), .SIDE_WIDTH($bits(ge_side_type))) u_mul_t2x (
      .clock, .reset, .valid_in(sq_valid_ff[NR]), .a_in(sq_res_ff[NR][NR-1:0]),
      .b_in(sq_side_ff[NR].my), .side_in(ge_side_in), .valid_out(ge_valid),
      .product(ge_t2x), .side_out(ge_side));
   gcli_mul #(.A_WIDTH(NR), .B_WIDTH(64), .SIDE_WIDTH(1)) u_mul_t2y (
      .clock, .reset, .valid_in(sq_valid_ff[NR]), .a_in(sq_res_ff[NR][NR-1:0]),
      .b_in(sq_side_ff[NR].mx), .side_in(1'b0), .valid_out(), .product(ge_t2y),
      .side_out());

   // ---- signed numerators: negate, add, take magnitude
   logic          f1_valid_ff, f2_valid_ff, f3_valid_ff;
   logic [SW-1:0] f1_ax_ff, f1_bx_ff, f1_ay_ff, f1_by_ff;
   logic [SW-1:0] f2_sx_ff, f2_sy_ff;
   logic [MW-1:0] f3_px_ff, f3_py_ff;
   logic          f3_negx_ff, f3_negy_ff;
   logic [127:0]  f1_d_ff, f2_d_ff, f3_d_ff;
   status_type    f1_status_ff, f2_status_ff, f3_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= ge_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
      f1_ax_ff <= ge_side.n1x ? -(SW'(ge_side.t1x)) : SW'(ge_side.t1x);
      f1_bx_ff <= ge_side.n2x ? -(SW'(ge_t2x)) : SW'(ge_t2x);
      f1_ay_ff <= ge_side.n1y ? -(SW'(ge_side.t1y)) : SW'(ge_side.t1y);
      f1_by_ff <= ge_side.n2y ? -(SW'(ge_t2y)) : SW'(ge_t2y);
      f1_d_ff      <= ge_side.d;
      f1_status_ff <= ge_side.status;

      f2_sx_ff     <= f1_ax_ff + f1_bx_ff;
      f2_sy_ff     <= f1_ay_ff + f1_by_ff;
      f2_d_ff      <= f1_d_ff;
      f2_status_ff <= f1_status_ff;

      // result is minus the quotient, so its sign is the opposite one
      f3_px_ff     <= f2_sx_ff[SW-1] ? MW'(-f2_sx_ff) : f2_sx_ff[MW-1:0];
      f3_py_ff     <= f2_sy_ff[SW-1] ? MW'(-f2_sy_ff) : f2_sy_ff[MW-1:0];
      f3_negx_ff   <= !f2_sx_ff[SW-1];
      f3_negy_ff   <= !f2_sy_ff[SW-1];
      f3_d_ff      <= f2_d_ff;
      f3_status_ff <= f2_status_ff;
   end

   // ---- division: overflow check, then 32 quotient bits, x and y lanes
   logic           dv_valid_ff  [33];
   logic [127:0]   dv_d_ff      [33];
   status_type     dv_status_ff [33];
   logic [DVW-1:0] dv_rem_ff    [33][2];
   logic [31:0]    dv_q_ff      [33][2];
   logic           dv_over_ff   [33][2];
   logic           dv_neg_ff    [33][2];

   logic [DVW-1:0] dv_lim;
   assign dv_lim = DVW'(f3_d_ff) << 32;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= f3_valid_ff;
      end
      dv_d_ff[0]       <= f3_d_ff;
      dv_status_ff[0]  <= f3_status_ff;
      dv_rem_ff[0][0]  <= DVW'(f3_px_ff);
      dv_rem_ff[0][1]  <= DVW'(f3_py_ff);
      dv_q_ff[0][0]    <= '0;
      dv_q_ff[0][1]    <= '0;
      dv_over_ff[0][0] <= DVW'(f3_px_ff) >= dv_lim;
      dv_over_ff[0][1] <= DVW'(f3_py_ff) >= dv_lim;
      dv_neg_ff[0][0]  <= f3_negx_ff;
      dv_neg_ff[0][1]  <= f3_negy_ff;
   end

   for (genvar j = 1; j <= 32; j++) begin : g_div
      logic [DVW-1:0] sub;
      logic [DVW-1:0] rem_in [2];
      logic [31:0]    q_in   [2];

      always_comb begin
         sub = DVW'(dv_d_ff[j-1]) << (32 - j);
         for (int l = 0; l < 2; l++) begin
            if (dv_rem_ff[j-1][l] >= sub) begin
               rem_in[l] = dv_rem_ff[j-1][l] - sub;
               q_in[l]   = dv_q_ff[j-1][l] | (32'd1 << (32 - j));
            end else begin
               rem_in[l] = dv_rem_ff[j-1][l];
               q_in[l]   = dv_q_ff[j-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
         dv_d_ff[j]      <= dv_d_ff[j-1];
         dv_status_ff[j] <= dv_status_ff[j-1];
         for (int l = 0; l < 2; l++) begin
            dv_rem_ff[j][l]  <= rem_in[l];
            dv_q_ff[j][l]    <= q_in[l];
            dv_over_ff[j][l] <= dv_over_ff[j-1][l];
            dv_neg_ff[j][l]  <= dv_neg_ff[j-1][l];
         end
      end
   end

   // ---- round half away from zero, then saturate and sign
   logic        rd_valid_ff;
   status_type  rd_status_ff;
   logic [32:0] rd_mag_ff  [2];
   logic        rd_over_ff [2];
   logic        rd_neg_ff  [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= dv_valid_ff[32];
      end
      rd_status_ff <= dv_status_ff[32];
      for (int l = 0; l < 2; l++) begin
         rd_mag_ff[l] <= {1'b0, dv_q_ff[32][l]} +
            (((DVW+1)'(dv_rem_ff[32][l]) << 1) >= (DVW+1)'(dv_d_ff[32]) ? 33'd1 : 33'd0);
         rd_over_ff[l] <= dv_over_ff[32][l];
         rd_neg_ff[l]  <= dv_neg_ff[32][l];
      end
   end

   logic [32:0] out_sat [2];
   logic [31:0] out_val [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         out_sat[l] = rd_neg_ff[l] ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
         if (!rd_over_ff[l] && (rd_mag_ff[l] <= out_sat[l])) begin
            out_sat[l] = rd_mag_ff[l];
         end
         out_val[l] = rd_neg_ff[l] ? 32'(-out_sat[l]) : out_sat[l][31:0];
         if (rd_status_ff != STATUS_VALID) begin
            out_val[l] = '0;
         end
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rd_valid_ff;
      end
      rsp_item_ff.point_x <= out_val[0];
      rsp_item_ff.point_y <= out_val[1];
      rsp_item_ff.status  <= rd_status_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---- checks
   a_item_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("accepted item produced no result at the expected cycle");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching accepted item");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != STATUS_VALID) |->
         (rsp_item.point_x == '0) && (rsp_item.point_y == '0))
      else $error("non-valid status with nonzero point");

endmodule

@@ bench/gcli_checker.sv @@
// Checker for great_circle_latitude_intersect_core: predicts each result from the
// accepted item with exact wide integer math and compares it in order. Uses gcli_pkg.
`timescale 1ns / 100ps

module gcli_checker #(
   parameter int FRAC_BITS = gcli_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  gcli_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  gcli_pkg::rsp_type rsp_item,
   output int                error_count,
   output int                pending_count
);
   import gcli_pkg::*;

   typedef logic signed [259:0] wide_type;

   rsp_type expected_points[$];

   // round(-num / den), ties away from zero, saturated to 32 bits
   function automatic logic signed [31:0] neg_div_round(input wide_type num,
                                                        input wide_type den);
      wide_type mag, quo, rem;
      logic     neg;
      neg = (num > 0);
      mag = (num < 0) ? -num : num;
      quo = mag / den;
      rem = mag % den;
      if (2 * rem >= den) quo = quo + 1;
      if (neg) begin
         if (quo > 64'sd2147483648) quo = 64'sd2147483648;
         return 32'(-quo);
      end
      if (quo > 64'sd2147483647) quo = 64'sd2147483647;
      return 32'(quo);
   endfunction

   function automatic wide_type floor_sqrt(input wide_type q);
      wide_type root, trial;
      root = '0;
      for (int i = 127; i >= 0; i--) begin
         trial = root | (wide_type'(1) << i);
         if (trial * trial <= q) root = trial;
      end
      return root;
   endfunction

   function automatic rsp_type predict_intersection(input req_type it);
      wide_type ax, ay, az, bx, by, bz, zh, nx, ny, nz, den, disc, root;
      rsp_type res;
      ax = wide_type'(it.a_x); ay = wide_type'(it.a_y); az = wide_type'(it.a_z);
      bx = wide_type'(it.b_x); by = wide_type'(it.b_y); bz = wide_type'(it.b_z);
      zh = wide_type'(it.plane_height);
      nx = ay * bz - az * by;
      ny = az * bx - ax * bz;
      nz = ax * by - ay * bx;
      den = nx * nx + ny * ny;
      res.point_x = '0;
      res.point_y = '0;
      if (den == 0) begin
         res.status = STATUS_DEGENERATE;
         return res;
      end
      disc = (den << (2 * FRAC_BITS)) - (den + nz * nz) * zh * zh;
      if (disc < 0) begin
         res.status = STATUS_NO_HIT;
         return res;
      end
      root = floor_sqrt(disc);
      res.point_x = neg_div_round(zh * nx * nz + root * ny, den);
      res.point_y = neg_div_round(zh * ny * nz - root * nx, den);
      res.status = STATUS_VALID;
      return res;
   endfunction

   assign pending_count = expected_points.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         error_count <= 0;
      end else begin
         if (start && !busy) expected_points.push_back(predict_intersection(req_item));
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10) $display("unexpected result %h", rsp_item);
            end else begin
               want = expected_points.pop_front();
               if (want.point_x !== rsp_item.point_x || want.point_y !== rsp_item.point_y
                   || want.status !== rsp_item.status) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display("mismatch: expected x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                              want.point_x, want.point_y, want.status,
                              rsp_item.point_x, rsp_item.point_y, rsp_item.status);
               end
            end
         end
      end
   end

endmodule

@@ bench/testbench.sv @@
// Top of the intersect core bench: clock, reset, directed and random items
// with sender gaps, and the verdict. Uses gcli_pkg, the core and gcli_checker.
`timescale 1ns / 100ps

module testbench;
   import gcli_pkg::*;

   localparam logic signed [31:0] ONE = 32'sh4000_0000;
   localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      error_count, pending_count;
   int      idle_pct;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   great_circle_latitude_intersect_core u_top (
      .clock, .reset, .start, .busy, .req_item, .rsp_valid, .rsp_item
   );

   gcli_checker u_checker (
      .clock, .reset, .start, .busy, .req_item, .rsp_valid, .rsp_item,
      .error_count, .pending_count
   );

   // holds the item until the core takes it, with random gaps before it
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // combined send at the current negedge; start stays high between back to back items
   task automatic send_fields(input logic signed [31:0] ax, ay, az, bx, by, bz, zh);
      req_type it;
      it = '{ax, ay, az, bx, by, bz, zh};
      send_item(it);
   endtask

   function automatic logic signed [31:0] unit_coord();
      return $signed($urandom_range(2 * 32'h4000_0000)) - ONE;
   endfunction

   initial begin
      req_type it;
      idle_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: tangent, equator, degenerate, no hit, extremes
      send_fields(0, 0, ONE, ONE, 0, 0, ONE);
      send_fields(0, 0, ONE, ONE, 0, 0, -ONE);
      send_fields(ONE, 0, 0, 0, ONE, 0, 0);
      send_fields(ONE, 0, 0, 0, 0, ONE, ONE >>> 1);
      send_fields(ONE, 0, 0, 0, 0, ONE, -(ONE >>> 1));
      send_fields(ONE, ONE, 0, ONE, ONE, 0, 0);
      send_fields(0, 0, 0, 0, 0, 0, 0);
      send_fields(0, 0, ONE, 0, 0, -ONE, 0);
      send_fields(ONE, 0, 0, 0, ONE, 0, ONE);
      send_fields(ONE, 0, 0, 0, ONE, ONE, ONE);
      send_fields(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV);
      send_fields(MAXV, MINV, MAXV, MINV, MAXV, 0, MINV);
      send_fields(MAXV, 0, MINV, 0, MAXV, MAXV, MINV);
      send_fields(MINV, MAXV, 0, 0, MINV, MAXV, 0);
      send_fields(1, 0, 0, 0, 1, 0, 0);
      send_fields(1, 0, 0, 0, 0, 1, 0);
      send_fields(-1, -1, -1, 1, -1, 1, -1);
      send_fields(ONE, 0, 0, 0, ONE >>> 8, ONE, 32'sh3fff_0000);
      for (int i = 0; i < 760; i++) begin
         case (i / 190)
            0: idle_pct = 0;
            1: idle_pct = 75;
            2: idle_pct = 0;
            default: idle_pct = 23;
         endcase
         if ($urandom_range(3) == 0) begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         end else begin
            it = '{unit_coord(), unit_coord(), unit_coord(), unit_coord(), unit_coord(),
                   unit_coord(), unit_coord()};
            if ($urandom_range(9) == 0) it.b_x = it.a_x;
            if ($urandom_range(9) == 0) begin
               it.b_x = it.a_x; it.b_y = it.a_y;
            end
         end
         send_item(it);
      end
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (260) @(posedge clock);
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin
      #4ms;
      $display("testbench failed");
      $finish;
   end

endmodule
